// ===== rtl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, codes and constants of the capacity reservation tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

  localparam int LOC_COUNT       = 6;
  localparam int LOC_W           = 3;
  localparam int OWNER_W         = 6;
  localparam int FIELD_W         = 48;
  localparam int STATUS_W        = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int OWNER_COUNT_DEF = 64;
  localparam int BYTE_WIDTH_DEF  = 48;

  // request kinds
  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 3'd0,
    STS_DOUBLE_RES  = 3'd1,
    STS_OVERCOMMIT  = 3'd2,
    STS_DOUBLE_REL  = 3'd3,
    STS_UNDERFLOW   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2,
    S_DONE  = 2'd3
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;     // write one zero entry of the held table
    logic load;      // capture a request and read its held entry
    logic exec;      // check and write back
    logic load_out;  // fill the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/crt_if.sv =====
// ----------------------------------------------------------------------------
// crt_if
// Request, result and configuration channels of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface crt_req_if
  import crt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LOC_W-1:0]   location;
  logic [OWNER_W-1:0] owner_id;
  logic [FIELD_W-1:0] amount;

  modport source (output valid, req_type, location, owner_id, amount, input ready);
  modport sink   (input valid, req_type, location, owner_id, amount, output ready);
endinterface

interface crt_rsp_if
  import crt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  used_bytes;
  logic [FIELD_W-1:0]  free_bytes;
  logic                above_limit;
  logic                all_clean;

  modport source (output valid, status, used_bytes, free_bytes, above_limit, all_clean,
                  input ready);
  modport sink   (input valid, status, used_bytes, free_bytes, above_limit, all_clean,
                  output ready);
endinterface

interface crt_cfg_if
  import crt_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/capacity_reservation_tracker.sv =====
// A request is captured, then checked and written back, and its result is
// loaded once the result register is free or drains. A new request waits for
// the last write-back, set by the read-modify-write of the held table (one
// read port, one write port). Configuration writes are taken at any time.
// Reset: limits and used counts read zero; the held table is then cleared one
// entry a cycle, 384 entries by default, and no request is taken meanwhile.
// ----------------------------------------------------------------------------
// capacity_reservation_tracker
// Per-location and per-owner byte reservation bookkeeping against limits.
// ----------------------------------------------------------------------------
`default_nettype none

module capacity_reservation_tracker
  import crt_pkg::*;
#(
  parameter int OWNER_COUNT = OWNER_COUNT_DEF,
  parameter int BYTE_WIDTH  = BYTE_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crt_req_if.sink    req_i,
  crt_rsp_if.source  rsp_o,
  crt_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  crt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crt_dp #(
    .OWNER_COUNT (OWNER_COUNT),
    .BYTE_WIDTH  (BYTE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .req_type_i    (req_i.req_type),
    .location_i    (req_i.location),
    .owner_id_i    (req_i.owner_id),
    .amount_i      (req_i.amount),
    .status_o      (rsp_o.status),
    .used_bytes_o  (rsp_o.used_bytes),
    .free_bytes_o  (rsp_o.free_bytes),
    .above_limit_o (rsp_o.above_limit),
    .all_clean_o   (rsp_o.all_clean)
  );

endmodule

`default_nettype wire

// ===== rtl/crt_ctrl.sv =====
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: clearing pass, request capture, check/write-back, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_ctrl
  import crt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        can_load;

  // result register is free or drains this cycle
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          state_d = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_DONE: begin
        cmd_o.load_out = can_load;
        in_ready_o     = can_load;
        cmd_o.load     = can_load && in_valid_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crt_dp.sv =====
// ----------------------------------------------------------------------------
// crt_dp
// Datapath: limit registers, used counters, held table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_dp
  import crt_pkg::*;
#(
  parameter int OWNER_COUNT = OWNER_COUNT_DEF,
  parameter int BYTE_WIDTH  = BYTE_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  // configuration write
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [FIELD_W-1:0]   cfg_data_i,
  // request fields
  input  wire logic                 req_type_i,
  input  wire logic [LOC_W-1:0]     location_i,
  input  wire logic [OWNER_W-1:0]   owner_id_i,
  input  wire logic [FIELD_W-1:0]   amount_i,
  // result fields
  output logic [STATUS_W-1:0]       status_o,
  output logic [FIELD_W-1:0]        used_bytes_o,
  output logic [FIELD_W-1:0]        free_bytes_o,
  output logic                      above_limit_o,
  output logic                      all_clean_o
);

  localparam int BW         = BYTE_WIDTH;
  localparam int OW         = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
  localparam int AW         = LOC_W + OW;
  localparam int HELD_DEPTH = LOC_COUNT << OW;

  logic [BW-1:0] limit_q [LOC_COUNT];
  logic [BW-1:0] used_q  [LOC_COUNT];
  logic [BW-1:0] held_mem [HELD_DEPTH];

  logic [AW-1:0] clr_cnt_q;

  // captured request
  logic          type_q;
  logic [LOC_W-1:0] loc_q;
  logic          loc_ok_q;
  logic          own_ok_q;
  logic [AW-1:0] addr_q;
  logic [BW-1:0] amt_q;
  logic [BW-1:0] held_q;
  logic [BW-1:0] free_q;

  // result register
  status_e       status_q;
  status_e       status_out_q;
  logic [FIELD_W-1:0] used_out_q;
  logic [FIELD_W-1:0] free_out_q;
  logic          over_q;
  logic          clean_q;

  // ---------------- configuration ----------------
  logic [BW+FIELD_W-1:0] cfg_ext;
  assign cfg_ext = {{BW{1'b0}}, cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOC_COUNT; i++) limit_q[i] <= '0;
    end else if (cfg_we_i && (32'(cfg_index_i) < LOC_COUNT)) begin
      limit_q[cfg_index_i] <= cfg_ext[BW-1:0];
    end
  end

  // ---------------- request capture ----------------
  logic                   in_loc_ok;
  logic                   in_own_ok;
  logic [LOC_W-1:0]       in_loc_sel;
  logic [OW+OWNER_W-1:0]  own_ext;
  logic [AW-1:0]          in_addr;
  logic [BW+FIELD_W-1:0]  amt_ext;
  logic [BW-1:0]          in_lim;
  logic [BW-1:0]          in_used;

  assign in_loc_ok  = 32'(location_i) < LOC_COUNT;
  assign in_own_ok  = 32'(owner_id_i) < OWNER_COUNT;
  assign in_loc_sel = in_loc_ok ? location_i : '0;
  assign own_ext    = {{OW{1'b0}}, owner_id_i};
  assign in_addr    = {in_loc_sel, own_ext[OW-1:0]};
  assign amt_ext    = {{BW{1'b0}}, amount_i};
  assign in_lim     = limit_q[in_loc_sel];
  assign in_used    = used_q[in_loc_sel];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q   <= req_type_i;
      loc_q    <= in_loc_sel;
      loc_ok_q <= in_loc_ok;
      own_ok_q <= in_own_ok;
      addr_q   <= in_addr;
      amt_q    <= amt_ext[BW-1:0];
      // free computed at capture, ahead of the check in exec
      free_q   <= (in_lim > in_used) ? (in_lim - in_used) : '0;
    end
  end

  // ---------------- check and update ----------------
  status_e       ex_status;
  logic          ex_write;
  logic [BW-1:0] ex_held;
  logic [BW-1:0] ex_used;
  logic [BW-1:0] cur_used;

  assign cur_used = used_q[loc_q];

  always_comb begin
    ex_status = STS_OK;
    ex_write  = 1'b0;
    ex_held   = held_q;
    ex_used   = cur_used;
    if (loc_ok_q && own_ok_q) begin
      if (type_q == REQ_RESERVE) begin
        if (held_q != '0) begin
          ex_status = STS_DOUBLE_RES;
        end else if (amt_q > free_q) begin
          ex_status = STS_OVERCOMMIT;
        end else begin
          ex_write = 1'b1;
          ex_held  = amt_q;
          ex_used  = cur_used + amt_q;
        end
      end else begin
        if (held_q == '0) begin
          ex_status = STS_DOUBLE_REL;
        end else if (amt_q > held_q) begin
          ex_status = STS_UNDERFLOW;
        end else begin
          ex_write = 1'b1;
          ex_held  = held_q - amt_q;
          ex_used  = (cur_used >= amt_q) ? (cur_used - amt_q) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= ex_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOC_COUNT; i++) used_q[i] <= '0;
    end else if (cmd_i.exec && ex_write) begin
      used_q[loc_q] <= ex_used;
    end
  end

  // ---------------- held table ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      held_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.exec && ex_write) begin
      held_mem[addr_q] <= ex_held;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q <= held_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o.clear_last = (32'(clr_cnt_q) == HELD_DEPTH - 1);

  // ---------------- result ----------------
  logic                  any_used;
  logic [BW-1:0]         res_lim;
  logic [BW-1:0]         res_free;
  logic [BW+FIELD_W-1:0] used_ext;
  logic [BW+FIELD_W-1:0] free_ext;

  always_comb begin
    any_used = 1'b0;
    for (int i = 0; i < LOC_COUNT; i++) begin
      any_used = any_used | (|used_q[i]);
    end
  end

  assign res_lim  = limit_q[loc_q];
  assign res_free = (res_lim > cur_used) ? (res_lim - cur_used) : '0;
  assign used_ext = {{FIELD_W{1'b0}}, cur_used};
  assign free_ext = {{FIELD_W{1'b0}}, res_free};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_out_q <= status_q;
      clean_q      <= !any_used;
      if (loc_ok_q) begin
        used_out_q <= used_ext[FIELD_W-1:0];
        free_out_q <= free_ext[FIELD_W-1:0];
        over_q     <= cur_used > res_lim;
      end else begin
        used_out_q <= '0;
        free_out_q <= '0;
        over_q     <= 1'b0;
      end
    end
  end

  assign status_o      = status_out_q;
  assign used_bytes_o  = used_out_q;
  assign free_bytes_o  = free_out_q;
  assign above_limit_o = over_q;
  assign all_clean_o   = clean_q;

endmodule

`default_nettype wire
